// ===== rtl/core/gpda_pkg.sv =====
// Shared widths, codes and control types for the gyro pointer delta accumulator.
package gpda_pkg;

	localparam int ACCUM_BITS = 40;
	localparam int RATE_BITS = 16;
	localparam int GAIN_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int DEADZONE_BITS = 15;
	localparam int SPR_BITS = 8;
	localparam int DMAX_BITS = 7;
	localparam int DELTA_BITS = 8;
	localparam int BTN_BITS = 3;
	localparam int REQ_BITS = 2;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 5;

	// Signed rate after optional negation times the gain as a signed operand.
	localparam int PROD_BITS = RATE_BITS + GAIN_BITS + 2;
	localparam int BACK_BITS = DELTA_BITS + FRAC_BITS;
	localparam int ADD_BITS = (PROD_BITS > BACK_BITS) ? PROD_BITS : BACK_BITS;
	localparam int WHOLE_BITS = ACCUM_BITS - FRAC_BITS;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_SAMPLE    = 2'd0,
		REQ_SENT_OK   = 2'd1,
		REQ_SENT_FAIL = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		REG_DEADZONE  = 3'd0,
		REG_GAIN      = 3'd1,
		REG_SPR       = 3'd2,
		REG_INVERT_X  = 3'd3,
		REG_INVERT_Y  = 3'd4,
		REG_DELTA_MAX = 3'd5
	} reg_idx_t;

	// What the final stage asks of one axis accumulator.
	typedef struct packed {
		logic upd;
		logic decide;
		logic clear;
	} axis_ctl_t;

endpackage

// ===== rtl/core/gpda_if.sv =====
// Valid/ready channel interfaces for the sample input and the report output.
interface gpda_in_if import gpda_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [REQ_BITS-1:0]         req_type;
	logic signed [RATE_BITS-1:0] rate_x;
	logic signed [RATE_BITS-1:0] rate_y;
	logic [BTN_BITS-1:0]         buttons;
	logic                        connected;

	modport source (output valid, req_type, rate_x, rate_y, buttons, connected, input ready);
	modport sink (input valid, req_type, rate_x, rate_y, buttons, connected, output ready);
endinterface

interface gpda_out_if import gpda_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [DELTA_BITS-1:0] delta_x;
	logic signed [DELTA_BITS-1:0] delta_y;
	logic [BTN_BITS-1:0]          button_bits;

	modport source (output valid, delta_x, delta_y, button_bits, input ready);
	modport sink (input valid, delta_x, delta_y, button_bits, output ready);
endinterface

// ===== rtl/core/gyro_pointer_delta_accumulator.sv =====
// Top level of the gyro pointer delta accumulator with its APB register file.
// Usage: items arrive on the item channel (valid/ready, one transfer per item):
// gyro samples carrying two turn rates, buttons and link state, or the outcome
// of the last report (sent ok or dropped). Cursor reports leave on the report
// channel; a sample gives at most one report and acknowledgements give none.
// The pipeline has three register stages: input register, scaled-rate register
// (after the rate-times-gain multiply) and the accumulator stage, which updates
// the accumulators, sample counter and pending report and loads the report
// register. One item is taken every cycle unless a stalled receiver has filled
// the stages; the accumulator stage is the only place where state is read and
// written, so consecutive items see each other's effects exactly. When the
// receiver stalls, the report register holds its contents and the earlier
// stages keep accepting items until they are full; items that give no report
// still wait behind a held report, keeping order simple.
// Reset (arst_n low, asynchronous) clears the accumulators, counter, pending and
// committed button state, empties every stage and loads the register defaults.
// Registers are written over APB at byte address 4*index and may only be
// changed while the block is idle; pready is always high.
module gyro_pointer_delta_accumulator import gpda_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	gpda_in_if.sink                  item,
	gpda_out_if.source               report,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	// Configuration registers.
	logic [DEADZONE_BITS-1:0] deadzone_q;
	logic [GAIN_BITS-1:0]     gain_q;
	logic [SPR_BITS-1:0]      spr_q;
	logic                     invert_x_q;
	logic                     invert_y_q;
	logic [DMAX_BITS-1:0]     delta_max_q;

	// Stage one: registered input item.
	logic                        v_s1;
	logic [REQ_BITS-1:0]         req_s1;
	logic signed [RATE_BITS-1:0] rate_x_s1;
	logic signed [RATE_BITS-1:0] rate_y_s1;
	logic [BTN_BITS-1:0]         btn_s1;
	logic                        conn_s1;

	// Stage two: scaled rates.
	logic                        v_s2;
	logic [REQ_BITS-1:0]         req_s2;
	logic signed [PROD_BITS-1:0] prod_x_s2;
	logic signed [PROD_BITS-1:0] prod_y_s2;
	logic [BTN_BITS-1:0]         btn_s2;
	logic                        conn_s2;

	// Block state and report register.
	logic [SPR_BITS-1:0]          count_q;
	logic [BTN_BITS-1:0]          last_btn_q;
	logic signed [DELTA_BITS-1:0] pend_dx_q;
	logic signed [DELTA_BITS-1:0] pend_dy_q;
	logic [BTN_BITS-1:0]          pend_btn_q;
	logic                         out_v_q;
	logic signed [DELTA_BITS-1:0] out_dx_q;
	logic signed [DELTA_BITS-1:0] out_dy_q;
	logic [BTN_BITS-1:0]          out_btn_q;

	logic                        cfg_wr;
	logic [2:0]                  cfg_idx;
	logic                        take_s1;
	logic                        take_s2;
	logic                        fire;
	logic signed [PROD_BITS-1:0] prod_x;
	logic signed [PROD_BITS-1:0] prod_y;
	logic signed [ADD_BITS-1:0]  add_x;
	logic signed [ADD_BITS-1:0]  add_y;
	axis_ctl_t                   axis_ctl;
	logic signed [DELTA_BITS-1:0] dx;
	logic signed [DELTA_BITS-1:0] dy;
	logic [SPR_BITS-1:0]         count_inc;
	logic [SPR_BITS-1:0]         period;
	logic                        is_sample;
	logic                        is_fail;
	logic                        decision;
	logic                        emit;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[APB_ADDR_BITS-1:2];

	always_comb begin
		unique case (cfg_idx)
			REG_DEADZONE:  prdata = APB_DATA_BITS'(deadzone_q);
			REG_GAIN:      prdata = APB_DATA_BITS'(gain_q);
			REG_SPR:       prdata = APB_DATA_BITS'(spr_q);
			REG_INVERT_X:  prdata = APB_DATA_BITS'(invert_x_q);
			REG_INVERT_Y:  prdata = APB_DATA_BITS'(invert_y_q);
			REG_DELTA_MAX: prdata = APB_DATA_BITS'(delta_max_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q  <= DEADZONE_BITS'(40);
			gain_q      <= GAIN_BITS'(590);
			spr_q       <= SPR_BITS'(2);
			invert_x_q  <= 1'b1;
			invert_y_q  <= 1'b1;
			delta_max_q <= DMAX_BITS'(127);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_DEADZONE:  deadzone_q  <= pwdata[DEADZONE_BITS-1:0];
				REG_GAIN:      gain_q      <= pwdata[GAIN_BITS-1:0];
				REG_SPR:       spr_q       <= pwdata[SPR_BITS-1:0];
				REG_INVERT_X:  invert_x_q  <= pwdata[0];
				REG_INVERT_Y:  invert_y_q  <= pwdata[0];
				REG_DELTA_MAX: delta_max_q <= pwdata[DMAX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	// The final stage moves whenever the report register is free or being emptied.
	assign fire = v_s2 && (!out_v_q || report.ready);
	assign take_s2 = !v_s2 || fire;
	assign take_s1 = !v_s1 || take_s2;
	assign item.ready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				v_s1 <= item.valid;
			end
			if (take_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			req_s1    <= item.req_type;
			rate_x_s1 <= item.rate_x;
			rate_y_s1 <= item.rate_y;
			btn_s1    <= item.buttons;
			conn_s1   <= item.connected;
		end
		if (take_s2) begin
			req_s2    <= req_s1;
			prod_x_s2 <= prod_x;
			prod_y_s2 <= prod_y;
			btn_s2    <= btn_s1;
			conn_s2   <= conn_s1;
		end
	end

	// ---------------------------------------------------------------- scaling
	gpda_scale u_scale_x (
		.rate     (rate_x_s1),
		.invert   (invert_x_q),
		.deadzone (deadzone_q),
		.gain     (gain_q),
		.product  (prod_x)
	);

	gpda_scale u_scale_y (
		.rate     (rate_y_s1),
		.invert   (invert_y_q),
		.deadzone (deadzone_q),
		.gain     (gain_q),
		.product  (prod_y)
	);

	// ---------------------------------------------------------------- accumulate and decide
	always_comb begin
		is_sample = (req_s2 == REQ_SAMPLE);
		is_fail = (req_s2 == REQ_SENT_FAIL);
		count_inc = count_q + SPR_BITS'(1);
		// A zero period behaves as one: every sample is a decision.
		period = (spr_q == '0) ? SPR_BITS'(1) : spr_q;
		decision = is_sample && (count_inc >= period);

		axis_ctl.upd = is_sample || is_fail;
		axis_ctl.decide = decision;
		axis_ctl.clear = !conn_s2;

		// A dropped report puts its whole pixels back into the accumulators.
		if (is_fail) begin
			add_x = ADD_BITS'($signed({pend_dx_q, {FRAC_BITS{1'b0}}}));
			add_y = ADD_BITS'($signed({pend_dy_q, {FRAC_BITS{1'b0}}}));
		end else begin
			add_x = ADD_BITS'(prod_x_s2);
			add_y = ADD_BITS'(prod_y_s2);
		end
	end

	assign emit = decision && conn_s2 && ((dx != '0) || (dy != '0) || (btn_s2 != last_btn_q));

	gpda_axis u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.ctl       (axis_ctl),
		.addend    (add_x),
		.delta_max (delta_max_q),
		.delta     (dx)
	);

	gpda_axis u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.ctl       (axis_ctl),
		.addend    (add_y),
		.delta_max (delta_max_q),
		.delta     (dy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			last_btn_q <= '0;
			pend_dx_q  <= '0;
			pend_dy_q  <= '0;
			pend_btn_q <= '0;
			out_v_q    <= 1'b0;
		end else begin
			out_v_q <= fire ? emit : (out_v_q && !report.ready);
			if (fire) begin
				unique case (req_s2)
					REQ_SAMPLE: begin
						count_q <= decision ? '0 : count_inc;
						if (emit) begin
							pend_dx_q  <= dx;
							pend_dy_q  <= dy;
							pend_btn_q <= btn_s2;
						end
					end
					REQ_SENT_OK: begin
						last_btn_q <= pend_btn_q;
						pend_dx_q  <= '0;
						pend_dy_q  <= '0;
					end
					REQ_SENT_FAIL: begin
						pend_dx_q  <= '0;
						pend_dy_q  <= '0;
						pend_btn_q <= last_btn_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_dx_q  <= dx;
			out_dy_q  <= dy;
			out_btn_q <= btn_s2;
		end
	end

	assign report.valid = out_v_q;
	assign report.delta_x = out_dx_q;
	assign report.delta_y = out_dy_q;
	assign report.button_bits = out_btn_q;

endmodule

// ===== rtl/core/gpda_scale.sv =====
// Rate conditioning for one axis: optional negation, deadzone and gain multiply.
module gpda_scale import gpda_pkg::*; (
	input  logic signed [RATE_BITS-1:0] rate,
	input  logic                        invert,
	input  logic [DEADZONE_BITS-1:0]    deadzone,
	input  logic [GAIN_BITS-1:0]        gain,
	output logic signed [PROD_BITS-1:0] product
);

	logic signed [RATE_BITS:0] r;
	logic [RATE_BITS:0]        mag;
	logic signed [RATE_BITS:0] r_dz;
	logic signed [GAIN_BITS:0] g;

	always_comb begin
		r = invert ? -(RATE_BITS+1)'(rate) : (RATE_BITS+1)'(rate);
		mag = r[RATE_BITS] ? $unsigned(-r) : $unsigned(r);
		// Rates strictly inside the deadzone are treated as no motion.
		r_dz = (mag < (RATE_BITS+1)'(deadzone)) ? '0 : r;
		g = $signed({1'b0, gain});
		product = PROD_BITS'(r_dz) * PROD_BITS'(g);
	end

endmodule

// ===== rtl/core/gpda_axis.sv =====
// One axis accumulator: saturating add, whole-pixel extraction, clamp and remainder.
module gpda_axis import gpda_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  axis_ctl_t                    ctl,
	input  logic signed [ADD_BITS-1:0]   addend,
	input  logic [DMAX_BITS-1:0]         delta_max,
	output logic signed [DELTA_BITS-1:0] delta
);

	localparam int SUM_BITS = ((ADD_BITS > ACCUM_BITS) ? ADD_BITS : ACCUM_BITS) + 1;

	logic signed [ACCUM_BITS-1:0] accum_q;
	logic signed [SUM_BITS-1:0]   sum;
	logic signed [ACCUM_BITS-1:0] a_sat;
	logic signed [ACCUM_BITS-1:0] biased;
	logic signed [WHOLE_BITS-1:0] whole;
	logic signed [WHOLE_BITS-1:0] lim;
	logic signed [WHOLE_BITS-1:0] clamped;
	logic signed [ACCUM_BITS-1:0] remainder;

	always_comb begin
		sum = SUM_BITS'(accum_q) + SUM_BITS'(addend);
		// Saturate when the bits above the accumulator's sign are not a sign extension.
		if (sum[SUM_BITS-1:ACCUM_BITS-1] != {(SUM_BITS-ACCUM_BITS+1){sum[SUM_BITS-1]}}) begin
			a_sat = sum[SUM_BITS-1] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
				: {1'b0, {(ACCUM_BITS-1){1'b1}}};
		end else begin
			a_sat = sum[ACCUM_BITS-1:0];
		end
		// Truncation toward zero: bias negative values by one less than a pixel.
		biased = a_sat + (a_sat[ACCUM_BITS-1] ? ACCUM_BITS'({FRAC_BITS{1'b1}}) : '0);
		whole = biased[ACCUM_BITS-1:FRAC_BITS];
		lim = $signed({{(WHOLE_BITS-DMAX_BITS){1'b0}}, delta_max});
		if (whole > lim) begin
			clamped = lim;
		end else if (whole < -lim) begin
			clamped = -lim;
		end else begin
			clamped = whole;
		end
		delta = clamped[DELTA_BITS-1:0];
		remainder = a_sat - $signed({{(WHOLE_BITS-DELTA_BITS){delta[DELTA_BITS-1]}},
			delta, {FRAC_BITS{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (fire && ctl.upd) begin
			if (!ctl.decide) begin
				accum_q <= a_sat;
			end else if (ctl.clear) begin
				accum_q <= '0;
			end else begin
				accum_q <= remainder;
			end
		end
	end

endmodule

// ===== verif/tb_gyro_pointer_delta_accumulator.sv =====
// Self-checking testbench for the gyro pointer delta accumulator: directed table, then random phases.
module tb_gyro_pointer_delta_accumulator;
	import gpda_pkg::*;

	// The spare request code carries no meaning and must be ignored by the block.
	localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
	localparam int CLK_HALF = 5;
	localparam int CYCLE_LIMIT = 400000;
	// Cycles to let pass after the last expected report before touching a register, so
	// that items which give no report have left all three pipeline stages.
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_SHOWN = 10;
	localparam longint PIXEL_Q16 = longint'(1) <<< FRAC_BITS;

	typedef struct packed {
		logic [REQ_BITS-1:0]         req;
		logic signed [RATE_BITS-1:0] rx;
		logic signed [RATE_BITS-1:0] ry;
		logic [BTN_BITS-1:0]         btn;
		logic                        conn;
	} sample_item_t;

	typedef struct packed {
		logic signed [DELTA_BITS-1:0] dx;
		logic signed [DELTA_BITS-1:0] dy;
		logic [BTN_BITS-1:0]          btn;
	} cursor_report_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One line of the directed table. Where typed is set, the expected report (or its
	// absence) is written into the row by hand instead of coming from the predictor.
	typedef struct {
		row_kind_t      kind;
		reg_idx_t       idx;
		logic [31:0]    val;
		sample_item_t   it;
		bit             typed;
		bit             typed_has;
		cursor_report_t typed_rep;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	gpda_in_if  item_ch ();
	gpda_out_if rep_ch ();

	gyro_pointer_delta_accumulator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.report  (rep_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_HALF) clk = ~clk;

	// Shadow of the register file as the predictor sees it.
	logic [DEADZONE_BITS-1:0] cfg_deadzone;
	logic [GAIN_BITS-1:0]     cfg_gain;
	logic [SPR_BITS-1:0]      cfg_spr;
	logic                     cfg_inv_x;
	logic                     cfg_inv_y;
	logic [DMAX_BITS-1:0]     cfg_delta_max;

	// Shadow of the block's state. Accumulators are held as 64-bit values and kept
	// inside the signed ACCUM_BITS range by the saturating add.
	longint              acc_x;
	longint              acc_y;
	logic [SPR_BITS-1:0] sample_cnt;
	logic [BTN_BITS-1:0] last_btn;
	logic [BTN_BITS-1:0] pend_btn;
	longint              pend_dx;
	longint              pend_dy;

	cursor_report_t expected_reports[$];
	int unsigned    fail_count = 0;
	int unsigned    cycle_count = 0;
	int             tx_idle_pct = 0;
	int             rx_idle_pct = 0;
	int             rx_hold = 0;

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_SHOWN) begin
			$display("%s", msg);
		end
	endtask

	// Adds p into an accumulator, pinning the sum at the signed ACCUM_BITS limits.
	function automatic longint sat_accumulate(input longint a, input longint p);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (ACCUM_BITS - 1)) - 1;
		lo = -hi - 1;
		if (p > 0 && a > hi - p) begin
			return hi;
		end
		if (p < 0 && a < lo - p) begin
			return lo;
		end
		return a + p;
	endfunction

	// Applies the optional inversion and the deadzone. Inverting the most negative
	// rate gives +32768, which the 64-bit arithmetic holds without wrapping.
	function automatic longint scaled_rate(input logic signed [RATE_BITS-1:0] raw,
	                                       input logic inv);
		longint r;
		longint mag;
		r = raw;
		if (inv) begin
			r = -r;
		end
		mag = (r < 0) ? -r : r;
		if (mag < longint'(cfg_deadzone)) begin
			r = 0;
		end
		return r;
	endfunction

	// Integer pixels of a Q16 accumulator, truncated toward zero and clamped to
	// plus or minus delta_max. A delta_max of zero clamps everything to zero.
	function automatic longint whole_pixels(input longint a);
		longint w;
		longint lim;
		lim = longint'(cfg_delta_max);
		if (a >= 0) begin
			w = a >>> FRAC_BITS;
		end else begin
			w = -((-a) >>> FRAC_BITS);
		end
		if (w > lim) begin
			w = lim;
		end
		if (w < -lim) begin
			w = -lim;
		end
		return w;
	endfunction

	// Moves the shadow state on by one accepted item and tells whether it gives a report.
	task automatic predict_cursor_report(input sample_item_t it, output bit has,
	                                     output cursor_report_t rep);
		longint rx;
		longint ry;
		longint dx;
		longint dy;
		int     n;
		has = 1'b0;
		rep = '0;
		case (it.req)
			REQ_SENT_OK: begin
				// The host has the report: its buttons become the committed ones.
				last_btn = pend_btn;
				pend_dx = 0;
				pend_dy = 0;
			end
			REQ_SENT_FAIL: begin
				// The report was lost: its movement goes back into the accumulators.
				acc_x = sat_accumulate(acc_x, pend_dx * PIXEL_Q16);
				acc_y = sat_accumulate(acc_y, pend_dy * PIXEL_Q16);
				pend_dx = 0;
				pend_dy = 0;
				pend_btn = last_btn;
			end
			REQ_SAMPLE: begin
				rx = scaled_rate(it.rx, cfg_inv_x);
				ry = scaled_rate(it.ry, cfg_inv_y);
				acc_x = sat_accumulate(acc_x, rx * longint'(cfg_gain));
				acc_y = sat_accumulate(acc_y, ry * longint'(cfg_gain));
				// A zero sample count per report behaves as one.
				n = (cfg_spr == '0) ? 1 : int'(cfg_spr);
				sample_cnt = sample_cnt + 1'b1;
				if (int'(sample_cnt) >= n) begin
					sample_cnt = '0;
					if (!it.conn) begin
						acc_x = 0;
						acc_y = 0;
					end else begin
						dx = whole_pixels(acc_x);
						acc_x = acc_x - dx * PIXEL_Q16;
						dy = whole_pixels(acc_y);
						acc_y = acc_y - dy * PIXEL_Q16;
						if (dx != 0 || dy != 0 || it.btn != last_btn) begin
							// A newer report simply replaces whatever was still pending.
							pend_dx = dx;
							pend_dy = dy;
							pend_btn = it.btn;
							has = 1'b1;
							rep.dx = DELTA_BITS'(dx);
							rep.dy = DELTA_BITS'(dy);
							rep.btn = it.btn;
						end
					end
				end
			end
			default: begin
				// The unused request code changes nothing.
			end
		endcase
	endtask

	// Writes one register over APB, then reads it straight back in a second transfer.
	// The predictor's copy is updated at once, which is safe because the block is idle.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] mask;
		logic [31:0] rd;
		mask = '0;
		case (idx)
			REG_DEADZONE: begin
				mask = (32'd1 << DEADZONE_BITS) - 1;
				cfg_deadzone = val[DEADZONE_BITS-1:0];
			end
			REG_GAIN: begin
				mask = (32'd1 << GAIN_BITS) - 1;
				cfg_gain = val[GAIN_BITS-1:0];
			end
			REG_SPR: begin
				mask = (32'd1 << SPR_BITS) - 1;
				cfg_spr = val[SPR_BITS-1:0];
			end
			REG_INVERT_X: begin
				mask = 32'd1;
				cfg_inv_x = val[0];
			end
			REG_INVERT_Y: begin
				mask = 32'd1;
				cfg_inv_y = val[0];
			end
			REG_DELTA_MAX: begin
				mask = (32'd1 << DMAX_BITS) - 1;
				cfg_delta_max = val[DMAX_BITS-1:0];
			end
			default: begin
			end
		endcase
		val = val & mask;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_BITS'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		// Straight into the setup cycle of the read-back, psel staying high.
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== val) begin
			note_failure($sformatf("register %s read back %0h, expected %0h",
			                       idx.name(), rd, val));
		end
	endtask

	// Offers one item and holds it until its transfer. Sometimes the sender idles
	// first. On the transfer edge the predictor runs.
	task automatic send_item(input sample_item_t it, input bit typed, input bit typed_has,
	                         input cursor_report_t typed_rep);
		bit             has;
		cursor_report_t rep;
		int             gap;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.req_type <= it.req;
		item_ch.rate_x <= it.rx;
		item_ch.rate_y <= it.ry;
		item_ch.buttons <= it.btn;
		item_ch.connected <= it.conn;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predict_cursor_report(it, has, rep);
		if (typed) begin
			has = typed_has;
			rep = typed_rep;
		end
		if (has) begin
			expected_reports.push_back(rep);
		end
	endtask

	// Stops offering items and waits until every expected report has come, then lets
	// the pipeline empty of items that give none.
	task automatic quiesce();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// A random turn rate. Drive phases push hard in one direction to reach saturation;
	// otherwise rates sit near the deadzone, at the extremes, at most 2000 or anywhere.
	function automatic logic signed [RATE_BITS-1:0] gen_rate(input int bias, input bit drive);
		int pick;
		int mag;
		int sgn;
		pick = $urandom_range(0, 99);
		sgn = (bias != 0) ? bias : ($urandom_range(0, 1) ? 1 : -1);
		if (drive && pick < 90) begin
			mag = $urandom_range(20000, 32767);
		end else if (pick < 10) begin
			case ($urandom_range(0, 3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
		end else if (pick < 30) begin
			return RATE_BITS'($urandom);
		end else if (pick < 65) begin
			mag = int'(cfg_deadzone) + int'($urandom_range(0, 60)) - 30;
			sgn = $urandom_range(0, 1) ? 1 : -1;
		end else begin
			mag = $urandom_range(0, 2000);
		end
		if (mag < 0) begin
			mag = 0;
		end
		if (mag > 32767) begin
			mag = 32767;
		end
		return RATE_BITS'(sgn * mag);
	endfunction

	function automatic row_t item_row(input logic [REQ_BITS-1:0] req, input int rx,
	                                  input int ry, input int btn, input bit conn);
		row_t r;
		r.kind = ROW_ITEM;
		r.idx = REG_DEADZONE;
		r.val = '0;
		r.it.req = req;
		r.it.rx = RATE_BITS'(rx);
		r.it.ry = RATE_BITS'(ry);
		r.it.btn = BTN_BITS'(btn);
		r.it.conn = conn;
		r.typed = 1'b0;
		r.typed_has = 1'b0;
		r.typed_rep = '0;
		return r;
	endfunction

	function automatic row_t item_row_exp(input logic [REQ_BITS-1:0] req, input int rx,
	                                      input int ry, input int btn, input bit conn,
	                                      input bit has, input int dx, input int dy);
		row_t r;
		r = item_row(req, rx, ry, btn, conn);
		r.typed = 1'b1;
		r.typed_has = has;
		r.typed_rep.dx = DELTA_BITS'(dx);
		r.typed_rep.dy = DELTA_BITS'(dy);
		r.typed_rep.btn = BTN_BITS'(btn);
		return r;
	endfunction

	function automatic row_t cfg_row(input reg_idx_t idx, input int val);
		row_t r;
		r = item_row(REQ_SAMPLE, 0, 0, 0, 1'b0);
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	// Report side: every transfer on the report channel is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		cursor_report_t want;
		cursor_report_t got;
		if (arst_n === 1'b1 && rep_ch.valid === 1'b1 && rep_ch.ready === 1'b1) begin
			got.dx = rep_ch.delta_x;
			got.dy = rep_ch.delta_y;
			got.btn = rep_ch.button_bits;
			if (expected_reports.size() == 0) begin
				note_failure($sformatf("unexpected report: dx %0d dy %0d buttons %0d",
				                       got.dx, got.dy, got.btn));
			end else begin
				want = expected_reports.pop_front();
				if (got.dx !== want.dx || got.dy !== want.dy || got.btn !== want.btn) begin
					note_failure($sformatf({"report mismatch: expected dx %0d dy %0d ",
					                        "buttons %0d, got dx %0d dy %0d buttons %0d"},
					                       want.dx, want.dy, want.btn,
					                       got.dx, got.dy, got.btn));
				end
			end
		end
	end

	// The receiver stalls in bursts, as often as the phase asks.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rep_ch.ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if ($urandom_range(0, 99) < rx_idle_pct) begin
			rep_ch.ready <= 1'b0;
			rx_hold = $urandom_range(0, 9);
		end else begin
			rep_ch.ready <= 1'b1;
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		row_t         dir_rows[$];
		sample_item_t it;
		int           phase;
		int           items_sent;
		int           n_items;
		int           pick;
		int           bias;
		int           link_down_pct;
		bit           drive;
		logic [BTN_BITS-1:0] btn_now;

		// Every input starts at a known value, with reset asserted from the start.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.req_type = REQ_SAMPLE;
		item_ch.rate_x = '0;
		item_ch.rate_y = '0;
		item_ch.buttons = '0;
		item_ch.connected = 1'b0;
		rep_ch.ready = 1'b0;

		// The predictor starts from the reset values of the block.
		cfg_deadzone = 40;
		cfg_gain = 590;
		cfg_spr = 2;
		cfg_inv_x = 1'b1;
		cfg_inv_y = 1'b1;
		cfg_delta_max = 127;
		acc_x = 0;
		acc_y = 0;
		sample_cnt = '0;
		last_btn = '0;
		pend_btn = '0;
		pend_dx = 0;
		pend_dy = 0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part, under the reset settings at first. A still pointer with
		// unchanged buttons stays silent; a button change alone gives a report.
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, 0, 0, 0, 1'b1, 1'b0, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, 0, 0, 0, 1'b1, 1'b0, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, 0, 0, 5, 1'b1, 1'b0, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, 0, 0, 5, 1'b1, 1'b1, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_SENT_OK, 0, 0, 0, 1'b1, 1'b0, 0, 0));
		// Full-scale rates, the most negative one inverted: both axes clamp.
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, -32768, 32767, 5, 1'b1, 1'b0, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, -32768, 32767, 5, 1'b1, 1'b1,
		                                127, -127));
		// The dropped report is put back; a spare code and a needless ok do nothing.
		dir_rows.push_back(item_row_exp(REQ_SENT_FAIL, 0, 0, 0, 1'b1, 1'b0, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_UNUSED, 32767, -32768, 7, 1'b0, 1'b0, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_SENT_OK, 0, 0, 0, 1'b1, 1'b0, 0, 0));
		// Rates either side of the deadzone edge.
		dir_rows.push_back(item_row(REQ_SAMPLE, 39, -39, 5, 1'b1));
		dir_rows.push_back(item_row(REQ_SAMPLE, 40, -40, 5, 1'b1));
		// Zero samples per report: every sample decides. Link down clears first.
		dir_rows.push_back(cfg_row(REG_SPR, 0));
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, 1000, 1000, 5, 1'b0, 1'b0, 0, 0));
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, 0, 0, 2, 1'b1, 1'b1, 0, 0));
		// Zero delta_max pins every delta to zero, so only the buttons report.
		dir_rows.push_back(cfg_row(REG_DELTA_MAX, 0));
		dir_rows.push_back(item_row_exp(REQ_SAMPLE, 32767, 32767, 2, 1'b1, 1'b1, 0, 0));
		// The other extreme of the delta_max, gain, deadzone and invert registers.
		dir_rows.push_back(cfg_row(REG_DELTA_MAX, 127));
		dir_rows.push_back(cfg_row(REG_GAIN, 65535));
		dir_rows.push_back(cfg_row(REG_DEADZONE, 32767));
		dir_rows.push_back(cfg_row(REG_INVERT_X, 0));
		dir_rows.push_back(cfg_row(REG_INVERT_Y, 0));
		dir_rows.push_back(item_row(REQ_SAMPLE, -32768, -32768, 7, 1'b1));
		dir_rows.push_back(item_row(REQ_SAMPLE, 32766, -32767, 7, 1'b1));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				quiesce();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].typed_has,
				          dir_rows[i].typed_rep);
			end
		end

		// Random phases. Each one starts from an idle block with fresh register values,
		// its own idling rates and its own mix of rates; two of them drive the
		// accumulators into saturation, one each way. Half way through each phase the
		// sender holds off until every report has arrived.
		phase = 0;
		items_sent = 0;
		btn_now = '0;
		while (items_sent < 1650 && phase < 20) begin
			drive = (phase == 1 || phase == 4);
			quiesce();
			case ($urandom_range(0, 3))
				0: write_reg(REG_DEADZONE, 0);
				1: write_reg(REG_DEADZONE, 32767);
				2: write_reg(REG_DEADZONE, $urandom_range(0, 200));
				default: write_reg(REG_DEADZONE, $urandom_range(0, 32767));
			endcase
			if (drive) begin
				write_reg(REG_DEADZONE, $urandom_range(0, 100));
				write_reg(REG_GAIN, 65535);
			end else begin
				case ($urandom_range(0, 3))
					0: write_reg(REG_GAIN, 0);
					1: write_reg(REG_GAIN, 65535);
					2: write_reg(REG_GAIN, $urandom_range(1, 4000));
					default: write_reg(REG_GAIN, $urandom_range(0, 65535));
				endcase
			end
			case ($urandom_range(0, 9))
				0: write_reg(REG_SPR, 255);
				1: write_reg(REG_SPR, 0);
				2: write_reg(REG_SPR, 1);
				default: write_reg(REG_SPR, $urandom_range(1, 8));
			endcase
			write_reg(REG_INVERT_X, $urandom_range(0, 1));
			write_reg(REG_INVERT_Y, $urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: write_reg(REG_DELTA_MAX, 0);
				1: write_reg(REG_DELTA_MAX, 1);
				2: write_reg(REG_DELTA_MAX, 127);
				default: write_reg(REG_DELTA_MAX, $urandom_range(1, 127));
			endcase

			pick = $urandom_range(0, 2);
			tx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
			pick = $urandom_range(0, 2);
			rx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
			if (phase == 1) begin
				bias = 1;
			end else if (phase == 4) begin
				bias = -1;
			end else begin
				bias = int'($urandom_range(0, 2)) - 1;
			end
			pick = $urandom_range(0, 2);
			link_down_pct = (drive || pick == 0) ? 0 : (pick == 1) ? 5 : 30;
			n_items = drive ? 400 : $urandom_range(150, 300);

			for (int k = 0; k < n_items; k++) begin
				if (k == n_items / 2) begin
					quiesce();
				end
				pick = $urandom_range(0, 99);
				if (drive ? (pick < 90) : (pick < 74)) begin
					it.req = REQ_SAMPLE;
				end else if (pick < 86) begin
					it.req = REQ_SENT_OK;
				end else if (pick < 97) begin
					it.req = REQ_SENT_FAIL;
				end else begin
					it.req = REQ_UNUSED;
				end
				it.rx = gen_rate(bias, drive);
				it.ry = gen_rate(-bias, drive);
				// Buttons mostly hold, so that unchanged-button decisions stay silent.
				if ($urandom_range(0, 99) < 15) begin
					btn_now = $urandom_range(0, 7);
				end
				it.btn = btn_now;
				it.conn = ($urandom_range(0, 99) >= link_down_pct);
				send_item(it, 1'b0, 1'b0, '0);
				if (it.req != REQ_UNUSED) begin
					items_sent++;
				end
			end
			phase++;
		end

		// Closing stretch at full rate: no idling on either side.
		quiesce();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(REG_SPR, $urandom_range(1, 3));
		write_reg(REG_DEADZONE, $urandom_range(0, 100));
		write_reg(REG_GAIN, $urandom_range(1000, 20000));
		for (int k = 0; k < 120; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				it.req = REQ_SAMPLE;
			end else if (pick < 90) begin
				it.req = REQ_SENT_OK;
			end else begin
				it.req = REQ_SENT_FAIL;
			end
			it.rx = gen_rate(0, 1'b0);
			it.ry = gen_rate(0, 1'b0);
			it.btn = $urandom_range(0, 7);
			it.conn = 1'b1;
			send_item(it, 1'b0, 1'b0, '0);
		end

		// Wait for the last reports and let the pipeline empty of anything stray.
		quiesce();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/gpda_pkg.sv
rtl/core/gpda_if.sv
rtl/core/gpda_scale.sv
rtl/core/gpda_axis.sv
rtl/core/gyro_pointer_delta_accumulator.sv
verif/tb_gyro_pointer_delta_accumulator.sv
